@@ rtl/dbfb_pkg.sv @@
package dbfb_pkg;

  // Default sizes of the block.
  localparam int MAX_SAMPLES_DEF      = 1024;
  localparam int MAX_BINS_DEF         = 64;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  // Configuration register indexes.
  localparam logic CFG_NUM_BINS   = 1'b0;
  localparam logic CFG_PHASE_STEP = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [6:0]  NUM_BINS_RST   = 7'd64;
  localparam logic [15:0] PHASE_STEP_RST = 16'd1024;

  // Fixed-point constants of the sine table.
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Rounded sums saturate to this magnitude.
  localparam logic [19:0] SUM_LIMIT = 20'd261120;

  // One Q1.15 table entry from the first-quadrant sine and cosine in Q30 and the quadrant.
  function automatic logic signed [15:0] sine_entry(input longint signed s,
                                                    input longint signed c,
                                                    input int unsigned quad);
    longint signed   v;
    longint unsigned m;
    longint unsigned r;
    bit              neg;
    case (quad)
      0:       v = s;
      1:       v = c;
      2:       v = -s;
      default: v = -c;
    endcase
    neg = (v < 0);
    m   = neg ? longint'(-v) : longint'(v);
    r   = (m + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return neg ? -16'(r) : 16'(r);
  endfunction

endpackage

@@ rtl/dft_bins_from_byte_samples.sv @@
// A sample without the last mark is stored and leaves the block idle. The last sample starts
// the bins; each bin takes one multiply-accumulate pass over the store, then rounding, two
// squaring steps on the shared multiplier and 19 square-root steps. The block is busy and takes
// no new sample until the last bin is out. A frame gives num_bins results (1 to MAX_BINS).
// Reset: synchronous, active low; clears the sequencer and the frame count, and sets the
// registers to 64 bins and a phase step of 1024. Results are strobes the receiver cannot stall.
module dft_bins_from_byte_samples #(
  parameter int MAX_SAMPLES      = dbfb_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_BINS         = dbfb_pkg::MAX_BINS_DEF,
  parameter int SINE_TABLE_DEPTH = dbfb_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_sample,
  input  logic               in_last_sample,
  output logic               out_valid,
  output logic [5:0]         out_bin_index,
  output logic signed [18:0] out_real_sum,
  output logic signed [18:0] out_imag_sum,
  output logic [18:0]        out_magnitude,
  output logic               out_samples_dropped,
  output logic               out_last_bin,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_SQ_RE = 3'd4;
  localparam logic [2:0] ST_SQ_IM = 3'd5;
  localparam logic [2:0] ST_ROOT  = 3'd6;

  localparam logic [37:0] ROOT_BIT_INIT = 38'd1 << 36;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [6:0]         num_bins_r, num_bins_nxt;
  logic [15:0]        phase_step_r, phase_step_nxt;
  logic [6:0]         bins_r, bins_nxt;
  logic [5:0]         k_r, k_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [15:0]        phase_r, phase_nxt;
  logic [15:0]        step_r, step_nxt;
  logic               v1_r, v2_r;
  logic               acc_clr;
  logic               out_valid_r, out_valid_nxt;

  logic [7:0]         mem [MAX_SAMPLES];
  logic [7:0]         x_r;
  logic signed [15:0] sin_r, cos_r;
  logic signed [24:0] prod_re_r, prod_im_r;
  logic signed [33:0] acc_re_r, acc_im_r;
  logic signed [18:0] re_r, im_r;
  logic signed [18:0] sq_src;
  logic signed [37:0] sq_prod;
  logic [37:0]        sq_r;
  logic [37:0]        rem_r, res_r, bit_r;
  logic [37:0]        trial;
  logic [37:0]        res_nxt;
  logic               accept;
  logic               store_ok;
  logic               bin_done;
  logic               last_k;

  logic [5:0]         out_bin_index_r;
  logic signed [18:0] out_real_sum_r, out_imag_sum_r;
  logic [18:0]        out_magnitude_r;
  logic               out_samples_dropped_r, out_last_bin_r;

  // Round half away from zero to an integer, then saturate.
  function automatic logic signed [18:0] round_sum(input logic signed [33:0] a);
    logic        neg;
    logic [33:0] m;
    logic [19:0] r;
    neg = a[33];
    m   = neg ? 34'(-a) : 34'(a);
    r   = 20'((35'(m) + 35'd16384) >> 15);
    if (r > dbfb_pkg::SUM_LIMIT) begin
      r = dbfb_pkg::SUM_LIMIT;
    end
    return neg ? -19'(r) : 19'(r);
  endfunction

  assign accept    = start && !busy;
  assign store_ok  = (count_r < CW'(MAX_SAMPLES));
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign last_k    = (k_r == 6'(bins_r - 7'd1));
  assign bin_done  = (state_r == ST_ROOT) && bit_r[0];

  // Shared squaring multiplier and one square-root step.
  assign sq_src  = (state_r == ST_SQ_RE) ? re_r : im_r;
  assign sq_prod = sq_src * sq_src;
  assign trial   = res_r + bit_r;
  assign res_nxt = (rem_r >= trial) ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  dbfb_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .phase(phase_r),
    .sin_r(sin_r),
    .cos_r(cos_r)
  );

  // Sequencer: store samples, then walk each bin over the store.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    num_bins_nxt   = num_bins_r;
    phase_step_nxt = phase_step_r;
    bins_nxt       = bins_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    acc_clr        = 1'b0;
    out_valid_nxt  = 1'b0;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == dbfb_pkg::CFG_NUM_BINS) begin
        num_bins_nxt = cfg_data[6:0];
      end else begin
        phase_step_nxt = cfg_data;
      end
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (store_ok) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_sample) begin
            if (num_bins_r == 7'd0) begin
              bins_nxt = 7'd1;
            end else if (num_bins_r > 7'(MAX_BINS)) begin
              bins_nxt = 7'(MAX_BINS);
            end else begin
              bins_nxt = num_bins_r;
            end
            k_nxt     = '0;
            n_nxt     = '0;
            phase_nxt = '0;
            step_nxt  = '0;
            acc_clr   = 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        n_nxt     = n_r + CW'(1);
        phase_nxt = phase_r + step_r;
        if (n_r == count_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_SQ_RE;
      ST_SQ_RE: state_nxt = ST_SQ_IM;
      ST_SQ_IM: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (bit_r[0]) begin
          out_valid_nxt = 1'b1;
          if (last_k) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 6'd1;
            step_nxt  = step_r + phase_step_r;
            n_nxt     = '0;
            phase_nxt = '0;
            acc_clr   = 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      num_bins_r   <= dbfb_pkg::NUM_BINS_RST;
      phase_step_r <= dbfb_pkg::PHASE_STEP_RST;
      bins_r       <= 7'd1;
      k_r          <= '0;
      n_r          <= '0;
      phase_r      <= '0;
      step_r       <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      num_bins_r   <= num_bins_nxt;
      phase_step_r <= phase_step_nxt;
      bins_r       <= bins_nxt;
      k_r          <= k_nxt;
      n_r          <= n_nxt;
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      v1_r         <= (state_r == ST_MAC);
      v2_r         <= v1_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Sample store: written on each accepted transaction while it has room, read once per cycle.
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem[count_r[AW-1:0]] <= in_sample;
    end
    x_r <= mem[n_r[AW-1:0]];
  end

  // Multiply-accumulate pipeline, then rounding, squares and the root.
  always_ff @(posedge clk) begin
    prod_re_r <= $signed({1'b0, x_r}) * cos_r;
    prod_im_r <= $signed({1'b0, x_r}) * sin_r;
    if (acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      acc_re_r <= acc_re_r + 34'(prod_re_r);
      acc_im_r <= acc_im_r - 34'(prod_im_r);
    end
    if (state_r == ST_ROUND) begin
      re_r <= round_sum(acc_re_r);
      im_r <= round_sum(acc_im_r);
    end
    if (state_r == ST_SQ_RE) begin
      sq_r <= 38'(sq_prod);
    end
    if (state_r == ST_SQ_IM) begin
      rem_r <= sq_r + 38'(sq_prod);
      res_r <= '0;
      bit_r <= ROOT_BIT_INIT;
    end else if (state_r == ST_ROOT) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
      end
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
    if (bin_done) begin
      out_bin_index_r       <= k_r;
      out_real_sum_r        <= re_r;
      out_imag_sum_r        <= im_r;
      out_magnitude_r       <= res_nxt[18:0];
      out_samples_dropped_r <= ovf_r;
      out_last_bin_r        <= last_k;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bin_index       = out_bin_index_r;
  assign out_real_sum        = out_real_sum_r;
  assign out_imag_sum        = out_imag_sum_r;
  assign out_magnitude       = out_magnitude_r;
  assign out_samples_dropped = out_samples_dropped_r;
  assign out_last_bin        = out_last_bin_r;

endmodule

@@ rtl/dbfb_sine_rom.sv @@
module dbfb_sine_rom #(
  parameter int SINE_TABLE_DEPTH = dbfb_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic [15:0]        phase,
  output logic signed [15:0] sin_r,
  output logic signed [15:0] cos_r
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = 16 + $clog2(SINE_TABLE_DEPTH + 1);

  logic signed [15:0] lut [SINE_TABLE_DEPTH];
  logic [15:0]        cos_phase;
  logic [PW-1:0]      sin_scaled;
  logic [PW-1:0]      cos_scaled;

  // Constant table of one full turn, built at elaboration from Taylor series in Q30.
  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_tab
    localparam longint unsigned Quad = (64'(4 * i)) / SINE_TABLE_DEPTH;
    localparam longint unsigned Rem  = 64'(4 * i) - Quad * SINE_TABLE_DEPTH;
    localparam longint unsigned Xarg = (Rem * dbfb_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
    localparam longint unsigned X2   = (Xarg * Xarg) >> 30;
    // Odd terms of the sine.
    localparam longint unsigned S1 = ((Xarg * X2) >> 30) / 64'd6;
    localparam longint unsigned S2 = ((S1 * X2) >> 30) / 64'd20;
    localparam longint unsigned S3 = ((S2 * X2) >> 30) / 64'd42;
    localparam longint unsigned S4 = ((S3 * X2) >> 30) / 64'd72;
    localparam longint unsigned S5 = ((S4 * X2) >> 30) / 64'd110;
    localparam longint unsigned S6 = ((S5 * X2) >> 30) / 64'd156;
    localparam longint unsigned S7 = ((S6 * X2) >> 30) / 64'd210;
    // Even terms of the cosine.
    localparam longint unsigned C1 = ((dbfb_pkg::Q30_ONE * X2) >> 30) / 64'd2;
    localparam longint unsigned C2 = ((C1 * X2) >> 30) / 64'd12;
    localparam longint unsigned C3 = ((C2 * X2) >> 30) / 64'd30;
    localparam longint unsigned C4 = ((C3 * X2) >> 30) / 64'd56;
    localparam longint unsigned C5 = ((C4 * X2) >> 30) / 64'd90;
    localparam longint unsigned C6 = ((C5 * X2) >> 30) / 64'd132;
    localparam longint unsigned C7 = ((C6 * X2) >> 30) / 64'd182;
    localparam longint signed SinQ30 = longint'(Xarg) - longint'(S1) + longint'(S2)
                                     - longint'(S3) + longint'(S4) - longint'(S5)
                                     + longint'(S6) - longint'(S7);
    localparam longint signed CosQ30 = longint'(dbfb_pkg::Q30_ONE) - longint'(C1)
                                     + longint'(C2) - longint'(C3) + longint'(C4)
                                     - longint'(C5) + longint'(C6) - longint'(C7);
    assign lut[i] = dbfb_pkg::sine_entry(SinQ30, CosQ30, 32'(Quad));
  end

  // Cosine is the sine a quarter turn ahead; scale phase onto the table.
  assign cos_phase  = phase + 16'd16384;
  assign sin_scaled = PW'(phase) * PW'(SINE_TABLE_DEPTH);
  assign cos_scaled = PW'(cos_phase) * PW'(SINE_TABLE_DEPTH);

  // Registered reads at two addresses.
  always_ff @(posedge clk) begin
    sin_r <= lut[sin_scaled[16 +: IW]];
    cos_r <= lut[cos_scaled[16 +: IW]];
  end

endmodule

@@ rtl/dbfb_checker.sv @@
module dbfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_last_sample,
  input logic       out_valid,
  input logic       out_last_bin,
  input logic [5:0] out_bin_index
);

  logic [5:0] prev_bin_r;
  logic       mid_frame_r;

  // Remember the last bin shown and whether its frame is still open.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_bin_r  <= '0;
      mid_frame_r <= 1'b0;
    end else if (out_valid) begin
      prev_bin_r  <= out_bin_index;
      mid_frame_r <= !out_last_bin;
    end
  end

  // A sample without the last mark never starts bin work.
  a_plain_sample: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_sample |=> !busy && !out_valid)
    else $error("block went busy on a sample without the last mark");

  // Results before the final bin come while the block is still busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_bin |-> busy)
    else $error("intermediate bin shown while idle");

  // After the final bin the block is idle again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |-> !busy)
    else $error("block still busy after final bin");

  // Results never come back to back.
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // Each frame starts at bin zero and bin numbers count up by one.
  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bin_index == (mid_frame_r ? prev_bin_r + 6'd1 : 6'd0))
    else $error("bin index out of order");

endmodule

bind dft_bins_from_byte_samples dbfb_checker u_dbfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_last_sample(in_last_sample),
  .out_valid     (out_valid),
  .out_last_bin  (out_last_bin),
  .out_bin_index (out_bin_index)
);

@@ verif/dft_bin_checker.sv @@
`timescale 1ns / 1ps

module dft_bin_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [7:0]         in_sample,
  input  logic               in_last_sample,
  input  logic               out_valid,
  input  logic [5:0]         out_bin_index,
  input  logic signed [18:0] out_real_sum,
  input  logic signed [18:0] out_imag_sum,
  input  logic [18:0]        out_magnitude,
  input  logic               out_samples_dropped,
  input  logic               out_last_bin,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam int STORE_DEPTH = dbfb_pkg::MAX_SAMPLES_DEF;
  localparam int TABLE_DEPTH = dbfb_pkg::SINE_TABLE_DEPTH_DEF;
  localparam int BIN_LIMIT   = dbfb_pkg::MAX_BINS_DEF;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic signed [18:0] real_sum;
    logic signed [18:0] imag_sum;
    logic [18:0]        magnitude;
    logic               dropped;
    logic               last_bin;
  } bin_result_t;

  bin_result_t       bin_results_q[$];
  logic signed [15:0] sine_lut[TABLE_DEPTH];
  logic [7:0]        frame_store[STORE_DEPTH];
  int unsigned       frame_len;
  bit                frame_overflow;
  logic [6:0]        bins_reg;
  logic [15:0]       step_reg;

  assign pending = bin_results_q.size();

  // Odd or even Taylor terms in Q30, evaluated in exact integer steps.
  function automatic longint signed taylor_q30(longint unsigned x, bit odd);
    longint unsigned x2, term, d;
    longint signed   acc;
    x2   = (x * x) >> 30;
    term = odd ? x : 64'd1073741824;
    acc  = longint'(term);
    d    = odd ? 64'd2 : 64'd1;
    for (int i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / (d * (d + 64'd1));
      d    = d + 64'd2;
      acc  = (i % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    return acc;
  endfunction

  // Rounds a Q30 value half away from zero to Q15 and clamps it.
  function automatic logic signed [15:0] to_q15(longint signed v);
    longint unsigned m, r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = (m + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return (v < 0) ? -16'(r) : 16'(r);
  endfunction

  // Rounds a 34-bit accumulator to an integer sum with saturation.
  function automatic logic signed [18:0] round_acc(logic [33:0] acc);
    longint signed   v;
    longint unsigned m, r;
    v = longint'(signed'(acc));
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = (m + 64'd16384) >> 15;
    if (r > 64'd261120) begin
      r = 64'd261120;
    end
    return (v < 0) ? -19'(r) : 19'(r);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Build the quarter-wave derived sine table once.
  initial begin
    longint unsigned q, rem, x;
    longint signed   s, c, v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      q   = (4 * i) / TABLE_DEPTH;
      rem = 4 * i - q * TABLE_DEPTH;
      x   = (rem * dbfb_pkg::HALF_PI_Q30) / TABLE_DEPTH;
      s   = taylor_q30(x, 1'b1);
      c   = taylor_q30(x, 1'b0);
      case (q)
        0:       v = s;
        1:       v = c;
        2:       v = -s;
        default: v = -c;
      endcase
      sine_lut[i] = to_q15(v);
    end
  end

  function automatic logic signed [15:0] sine_at(logic [15:0] ph);
    return sine_lut[(32'(ph) * TABLE_DEPTH) >> 16];
  endfunction

  // Evaluate every bin of the stored frame and queue the expected results.
  task automatic predict_bins();
    int unsigned        nbins;
    logic [15:0]        bstep, ph;
    logic [33:0]        re_acc, im_acc;
    logic signed [18:0] re, im;
    longint signed      xs, cs, ss;
    bin_result_t        r;
    nbins = (bins_reg < 1) ? 1 : (bins_reg > BIN_LIMIT) ? BIN_LIMIT : bins_reg;
    for (int k = 0; k < nbins; k++) begin
      bstep  = 16'(k * step_reg);
      ph     = '0;
      re_acc = '0;
      im_acc = '0;
      for (int n = 0; n < frame_len; n++) begin
        xs     = frame_store[n];
        cs     = sine_at(ph + 16'd16384);
        ss     = sine_at(ph);
        re_acc = re_acc + 34'(xs * cs);
        im_acc = im_acc - 34'(xs * ss);
        ph     = ph + bstep;
      end
      re            = round_acc(re_acc);
      im            = round_acc(im_acc);
      r.bin_index   = 6'(k);
      r.real_sum    = re;
      r.imag_sum    = im;
      r.magnitude   = 19'(floor_sqrt(longint'(re) * re + longint'(im) * im));
      r.dropped     = frame_overflow;
      r.last_bin    = (k + 1 == nbins);
      bin_results_q.push_back(r);
    end
    frame_len      = 0;
    frame_overflow = 0;
  endtask

  // Follow configuration writes, input transactions and result strobes.
  always @(posedge clk) begin
    bin_result_t e;
    if (!rst_n) begin
      frame_len      = 0;
      frame_overflow = 0;
      bins_reg       = dbfb_pkg::NUM_BINS_RST;
      step_reg       = dbfb_pkg::PHASE_STEP_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dbfb_pkg::CFG_NUM_BINS) begin
          bins_reg = cfg_data[6:0];
        end else begin
          step_reg = cfg_data;
        end
      end
      if (out_valid) begin
        if (bin_results_q.size() == 0) begin
          $error("unexpected bin result, bin_index %0d", out_bin_index);
          errors++;
        end else begin
          e = bin_results_q.pop_front();
          if (out_bin_index !== e.bin_index) begin
            $error("bin_index exp %0d got %0d", e.bin_index, out_bin_index);
            errors++;
          end
          if (out_real_sum !== e.real_sum) begin
            $error("real_sum exp %0d got %0d", e.real_sum, out_real_sum);
            errors++;
          end
          if (out_imag_sum !== e.imag_sum) begin
            $error("imag_sum exp %0d got %0d", e.imag_sum, out_imag_sum);
            errors++;
          end
          if (out_magnitude !== e.magnitude) begin
            $error("magnitude exp %0d got %0d", e.magnitude, out_magnitude);
            errors++;
          end
          if (out_samples_dropped !== e.dropped) begin
            $error("samples_dropped exp %0d got %0d", e.dropped, out_samples_dropped);
            errors++;
          end
          if (out_last_bin !== e.last_bin) begin
            $error("last_bin exp %0d got %0d", e.last_bin, out_last_bin);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (frame_len < STORE_DEPTH) begin
          frame_store[frame_len] = in_sample;
          frame_len = frame_len + 1;
        end else begin
          frame_overflow = 1;
        end
        if (in_last_sample) begin
          predict_bins();
        end
      end
    end
  end

  initial errors = 0;

endmodule

@@ verif/dft_bins_from_byte_samples_tb.sv @@
`timescale 1ns / 1ps

module dft_bins_from_byte_samples_tb;

  localparam longint CYCLE_LIMIT = 3000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [7:0]         in_sample;
  logic               in_last_sample;
  logic               out_valid;
  logic [5:0]         out_bin_index;
  logic signed [18:0] out_real_sum;
  logic signed [18:0] out_imag_sum;
  logic [18:0]        out_magnitude;
  logic               out_samples_dropped;
  logic               out_last_bin;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  int                 errors;
  int                 pending;
  int                 idle_pct;
  longint             cycles;

  dft_bins_from_byte_samples i_dut (.*);

  dft_bin_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One sample transaction, with random idle cycles ahead of it.
  task automatic send_sample(logic [7:0] value, logic is_last);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_sample      <= value;
    in_last_sample <= is_last;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_frame(int len);
    for (int i = 0; i < len; i++) begin
      send_sample(8'($urandom), i == len - 1);
    end
  endtask

  // Let the block drain before a register changes.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bins(int nb, int stp);
    write_reg(dbfb_pkg::CFG_NUM_BINS, 16'(nb));
    write_reg(dbfb_pkg::CFG_PHASE_STEP, 16'(stp));
  endtask

  initial begin
    int nb, sent;
    cycles         = 0;
    idle_pct       = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_sample      = '0;
    in_last_sample = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = dbfb_pkg::CFG_NUM_BINS;
    cfg_data       = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset setting: extreme samples, single-sample frame.
    send_sample(8'd255, 1'b1);
    send_sample(8'd0, 1'b1);
    for (int i = 0; i < 8; i++) send_sample(8'd255, i == 7);
    for (int i = 0; i < 6; i++) send_sample(i % 2 ? 8'd255 : 8'd0, i == 5);

    // Bin count of zero acts as one bin; largest phase step.
    set_bins(0, 65535);
    send_sample(8'd200, 1'b0);
    send_sample(8'd17, 1'b1);
    // Bin count above the maximum acts as the maximum.
    set_bins(127, 0);
    send_frame(3);
    // A few bins at a third of a turn per bin.
    set_bins(3, 21845);
    send_frame(5);
    set_bins(64, 1024);
    send_frame(2);

    // Random frames over four idling phases.
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 87 : (p == 3) ? 30 : 0;
      sent = 0;
      while (sent < 28) begin
        nb = $urandom_range(64, 1);
        if ($urandom_range(3, 0) == 0) begin
          set_bins($urandom_range(127, 0), $urandom_range(65535, 0));
        end else begin
          set_bins(nb, (65536 + nb / 2) / nb);
        end
        for (int f = 0; f < 3; f++) begin
          nb = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
          send_frame(nb);
          sent += nb;
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dbfb_pkg.sv
rtl/dbfb_sine_rom.sv
rtl/dft_bins_from_byte_samples.sv
rtl/dbfb_checker.sv
verif/dft_bin_checker.sv
verif/dft_bins_from_byte_samples_tb.sv
